// ===== rtl/generational_slot_table_defines.svh =====
// Assertion macros for the generational slot table checker.
// Needs nothing else; included by the checker file only.
`ifndef GENERATIONAL_SLOT_TABLE_DEFINES_SVH
`define GENERATIONAL_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define GST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gst_pkg.sv =====
// Shared types and constants for the generational slot table.
// No dependencies; imported by every module of the block but gst_ram.
`timescale 1ns / 1ps

package gst_pkg;

    localparam int SLOTS        = 256;
    localparam int GEN_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int SLOT_BITS    = $clog2(SLOTS);
    localparam int CNT_BITS     = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_RESOLVE = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_CLEAR   = 2'd3
    } t_gst_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_EXEC
    } t_gst_state;

    typedef struct packed {
        logic [GEN_BITS-1:0]     gen;
        logic                    occ;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_slot_entry;

    localparam int ENTRY_BITS = $bits(t_slot_entry);

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic pop;
        logic exec;
    } t_gst_cmd;

    // datapath -> controller
    typedef struct packed {
        logic stack_nonempty;
    } t_gst_status;

endpackage

// ===== rtl/gst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the slot entries and the free stack.
`timescale 1ns / 1ps

module gst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gst_ctrl.sv =====
// Sequencer for the slot table: accept, optional free-stack pop, execute.
// Depends on gst_pkg.
`timescale 1ns / 1ps

module gst_ctrl import gst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_op,
    input  t_gst_status i_status,
    output t_gst_cmd    o_cmd,
    output logic        o_busy
);

    t_gst_state r_state;
    t_gst_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    // reuse from the free stack needs the popped slot's entry read first
                    if (t_gst_op'(i_op) == OP_ADD && i_status.stack_nonempty) begin
                        n_state = ST_POP;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/gst_datapath.sv =====
// Slot table datapath: counters, slot entry RAM, free stack RAM, result regs.
// Depends on gst_pkg and gst_ram.
`timescale 1ns / 1ps

module gst_datapath import gst_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_gst_cmd                i_cmd,
    output t_gst_status             o_status,
    input  logic [1:0]              i_op,
    input  logic [PAYLOAD_BITS-1:0] i_payload_in,
    input  logic [SLOT_BITS-1:0]    i_handle_slot,
    input  logic [GEN_BITS-1:0]     i_handle_gen,
    output logic                    o_valid,
    output logic                    o_ok,
    output logic [SLOT_BITS-1:0]    o_out_slot,
    output logic [GEN_BITS-1:0]     o_out_gen,
    output logic [PAYLOAD_BITS-1:0] o_payload_out
);

    localparam logic [GEN_BITS-1:0] GEN_MAX = {GEN_BITS{1'b1}};

    logic [CNT_BITS-1:0]     r_used_count, n_used_count;
    logic [CNT_BITS-1:0]     r_free_top, n_free_top;

    t_gst_op                 r_op;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [SLOT_BITS-1:0]    r_hs;
    logic [GEN_BITS-1:0]     r_hg;
    logic                    r_from_stack;

    logic                    r_valid;
    logic                    r_ok;
    logic [SLOT_BITS-1:0]    r_out_slot;
    logic [GEN_BITS-1:0]     r_out_gen;
    logic [PAYLOAD_BITS-1:0] r_payload_out;

    // RAM ports
    logic                    slot_we;
    logic [SLOT_BITS-1:0]    slot_waddr;
    t_slot_entry             slot_wdata;
    logic [SLOT_BITS-1:0]    slot_raddr;
    logic [ENTRY_BITS-1:0]   slot_rdata_raw;
    t_slot_entry             slot_rd;

    logic                    stack_we;
    logic [SLOT_BITS-1:0]    stack_waddr;
    logic [SLOT_BITS-1:0]    stack_raddr;
    logic [SLOT_BITS-1:0]    stack_rdata;

    logic                    res_ok;
    logic [SLOT_BITS-1:0]    res_slot;
    logic [GEN_BITS-1:0]     res_gen;
    logic [PAYLOAD_BITS-1:0] res_payload;
    logic                    live;
    logic [CNT_BITS-1:0]     top_minus_one;

    assign o_status.stack_nonempty = (r_free_top != '0);

    assign top_minus_one = r_free_top - CNT_BITS'(1);
    assign stack_raddr   = top_minus_one[SLOT_BITS-1:0];
    assign slot_raddr    = i_cmd.pop ? stack_rdata : i_handle_slot;
    assign slot_rd       = t_slot_entry'(slot_rdata_raw);

    gst_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata_raw)
    );

    gst_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (r_hs),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    // beat registers; r_hs becomes the popped slot on the pop step
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op         <= t_gst_op'(i_op);
            r_payload    <= i_payload_in;
            r_hs         <= i_handle_slot;
            r_hg         <= i_handle_gen;
            r_from_stack <= o_status.stack_nonempty;
        end else if (i_cmd.pop) begin
            r_hs <= stack_rdata;
        end
    end

    assign live = (CNT_BITS'(r_hs) < r_used_count) && slot_rd.occ && (slot_rd.gen == r_hg);

    always_comb begin
        n_used_count = r_used_count;
        n_free_top   = r_free_top;
        slot_we      = 1'b0;
        slot_waddr   = r_hs;
        slot_wdata   = slot_rd;
        stack_we     = 1'b0;
        stack_waddr  = r_free_top[SLOT_BITS-1:0];
        res_ok       = 1'b0;
        res_slot     = '0;
        res_gen      = '0;
        res_payload  = '0;
        if (i_cmd.exec) begin
            case (r_op)
                OP_ADD: begin
                    if (r_from_stack) begin
                        n_free_top         = top_minus_one;
                        slot_we            = 1'b1;
                        slot_wdata.occ     = 1'b1;
                        slot_wdata.payload = r_payload;
                        res_ok             = 1'b1;
                        res_slot           = r_hs;
                        res_gen            = slot_rd.gen;
                    end else if (r_used_count < CNT_BITS'(SLOTS)) begin
                        n_used_count       = r_used_count + CNT_BITS'(1);
                        slot_we            = 1'b1;
                        slot_waddr         = r_used_count[SLOT_BITS-1:0];
                        slot_wdata.gen     = '0;
                        slot_wdata.occ     = 1'b1;
                        slot_wdata.payload = r_payload;
                        res_ok             = 1'b1;
                        res_slot           = r_used_count[SLOT_BITS-1:0];
                    end
                end
                OP_RESOLVE: begin
                    if (live) begin
                        res_ok      = 1'b1;
                        res_payload = slot_rd.payload;
                    end
                end
                OP_REMOVE: begin
                    if (live) begin
                        res_ok         = 1'b1;
                        slot_we        = 1'b1;
                        slot_wdata.occ = 1'b0;
                        // all-ones generation retires the slot
                        if (slot_rd.gen != GEN_MAX) begin
                            slot_wdata.gen = slot_rd.gen + GEN_BITS'(1);
                            if (r_free_top < CNT_BITS'(SLOTS)) begin
                                stack_we   = 1'b1;
                                n_free_top = r_free_top + CNT_BITS'(1);
                            end
                        end
                    end
                end
                OP_CLEAR: begin
                    n_used_count = '0;
                    n_free_top   = '0;
                    res_ok       = 1'b1;
                end
                default: begin
                    res_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_count <= '0;
            r_free_top   <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_used_count <= n_used_count;
            r_free_top   <= n_free_top;
            r_valid      <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok          <= res_ok;
            r_out_slot    <= res_slot;
            r_out_gen     <= res_gen;
            r_payload_out <= res_payload;
        end
    end

    assign o_valid       = r_valid;
    assign o_ok          = r_ok;
    assign o_out_slot    = r_out_slot;
    assign o_out_gen     = r_out_gen;
    assign o_payload_out = r_payload_out;

endmodule

// ===== rtl/generational_slot_table.sv =====
// Top level of the generational slot table: controller plus datapath.
// Depends on gst_pkg, gst_ctrl, gst_datapath (and gst_ram below it).
//
// Usage:
//   A command beat (i_op, i_payload_in, i_handle_slot, i_handle_gen) is taken
//   on a rising edge with start high and busy low. Ops: add, resolve, remove,
//   clear. Every command gives exactly one result beat.
//   The result sits on o_ok, o_out_slot, o_out_gen, o_payload_out for one
//   cycle with o_valid high; there is no back-pressure on the result side.
//   After the accept step comes the execute step, whose result is
//   registered; an add that reuses a slot from the free stack has a pop
//   step between them: the stack RAM read feeding the slot entry RAM read.
//   Busy stays high through the pop and execute steps, so a command is not
//   taken until the slot entry RAM has been read and then written.
//   A new command may be taken in the cycle its predecessor's result shows.
//   Reset (synchronous, active low) empties the table: the used count and
//   the free-stack depth go to zero; RAM contents are left as they are and
//   their stale data is never used before being written again.
`timescale 1ns / 1ps

module generational_slot_table import gst_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_op,
    input  logic [PAYLOAD_BITS-1:0] i_payload_in,
    input  logic [SLOT_BITS-1:0]    i_handle_slot,
    input  logic [GEN_BITS-1:0]     i_handle_gen,
    output logic                    o_valid,
    output logic                    o_ok,
    output logic [SLOT_BITS-1:0]    o_out_slot,
    output logic [GEN_BITS-1:0]     o_out_gen,
    output logic [PAYLOAD_BITS-1:0] o_payload_out
);

    t_gst_cmd    cmd;
    t_gst_status status;

    gst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    gst_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (i_op),
        .i_payload_in  (i_payload_in),
        .i_handle_slot (i_handle_slot),
        .i_handle_gen  (i_handle_gen),
        .o_valid       (o_valid),
        .o_ok          (o_ok),
        .o_out_slot    (o_out_slot),
        .o_out_gen     (o_out_gen),
        .o_payload_out (o_payload_out)
    );

endmodule

// ===== rtl/gst_checker.sv =====
// Port-level checks for the generational slot table, bound to the top level.
// Depends on gst_pkg and generational_slot_table_defines.svh.
`timescale 1ns / 1ps
`include "generational_slot_table_defines.svh"

module gst_checker import gst_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [1:0]              i_op,
    input logic [PAYLOAD_BITS-1:0] i_payload_in,
    input logic [SLOT_BITS-1:0]    i_handle_slot,
    input logic [GEN_BITS-1:0]     i_handle_gen,
    input logic                    o_valid,
    input logic                    o_ok,
    input logic [SLOT_BITS-1:0]    o_out_slot,
    input logic [GEN_BITS-1:0]     o_out_gen,
    input logic [PAYLOAD_BITS-1:0] o_payload_out
);

    `GST_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "no busy after accept")
    `GST_ASSERT_IMP(a_result_idle, i_clk, i_rst_n, o_valid, !busy, "result beat while busy")
    `GST_ASSERT_IMP(a_busy_end_result, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_valid, "busy ended without result")
    `GST_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
    `GST_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_valid && !o_ok, o_out_slot == '0 && o_out_gen == '0 && o_payload_out == '0, "failed result with non-zero fields")

endmodule

bind generational_slot_table gst_checker u_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for generational_slot_table: directed, fill, generation walk, random.
// Depends on gst_pkg and the generational_slot_table RTL; keeps its own mirror of the table.
`timescale 1ns / 1ps

module testbench;
    import gst_pkg::*;

    typedef struct packed {
        logic                    ok;
        logic [SLOT_BITS-1:0]    slot;
        logic [GEN_BITS-1:0]     gen;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_table_result;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1240;
    localparam int GEN_WALK       = 64;
    localparam logic [GEN_BITS-1:0] GEN_ALL_ONES = '1;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    start         = 1'b0;
    logic                    busy;
    logic [1:0]              i_op          = OP_CLEAR;
    logic [PAYLOAD_BITS-1:0] i_payload_in  = '0;
    logic [SLOT_BITS-1:0]    i_handle_slot = '0;
    logic [GEN_BITS-1:0]     i_handle_gen  = '0;
    logic                    o_valid;
    logic                    o_ok;
    logic [SLOT_BITS-1:0]    o_out_slot;
    logic [GEN_BITS-1:0]     o_out_gen;
    logic [PAYLOAD_BITS-1:0] o_payload_out;

    // mirror of the table
    int unsigned             used_cnt   = 0;
    int unsigned             free_depth = 0;
    logic [GEN_BITS-1:0]     gen_mem  [SLOTS];
    bit                      occ_mem  [SLOTS];
    logic [PAYLOAD_BITS-1:0] pay_mem  [SLOTS];
    logic [SLOT_BITS-1:0]    free_mem [SLOTS];

    t_table_result pending_results[$];
    t_table_result oldest;
    int            fail_count   = 0;
    int            stall_cycles = 0;
    int            idle_pct     = 0;

    generational_slot_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_payload_in  (i_payload_in),
        .i_handle_slot (i_handle_slot),
        .i_handle_gen  (i_handle_gen),
        .o_valid       (o_valid),
        .o_ok          (o_ok),
        .o_out_slot    (o_out_slot),
        .o_out_gen     (o_out_gen),
        .o_payload_out (o_payload_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit handle_live(logic [SLOT_BITS-1:0] hs, logic [GEN_BITS-1:0] hg);
        return (hs < used_cnt) && occ_mem[hs] && (gen_mem[hs] == hg);
    endfunction

    // Applies one command to the mirror and returns the result it should give.
    function automatic t_table_result table_model_step(t_gst_op op,
                                                       logic [PAYLOAD_BITS-1:0] pay,
                                                       logic [SLOT_BITS-1:0] hs,
                                                       logic [GEN_BITS-1:0] hg);
        t_table_result r;
        int unsigned   s;
        r = '0;
        s = 0;
        case (op)
            OP_ADD: begin
                if (free_depth > 0) begin
                    free_depth--;
                    s = 32'(free_mem[free_depth]);
                    r.ok = 1'b1;
                end else if (used_cnt < SLOTS) begin
                    s = used_cnt;
                    used_cnt++;
                    gen_mem[s] = '0;
                    r.ok = 1'b1;
                end
                if (r.ok) begin
                    pay_mem[s] = pay;
                    occ_mem[s] = 1'b1;
                    r.slot = s[SLOT_BITS-1:0];
                    r.gen  = gen_mem[s];
                end
            end
            OP_RESOLVE: begin
                if (handle_live(hs, hg)) begin
                    r.ok      = 1'b1;
                    r.payload = pay_mem[hs];
                end
            end
            OP_REMOVE: begin
                if (handle_live(hs, hg)) begin
                    occ_mem[hs] = 1'b0;
                    // a slot at the top generation is retired, not recycled
                    if (gen_mem[hs] != GEN_ALL_ONES) begin
                        gen_mem[hs] = gen_mem[hs] + 1'b1;
                        if (free_depth < SLOTS) begin
                            free_mem[free_depth] = hs;
                            free_depth++;
                        end
                    end
                    r.ok = 1'b1;
                end
            end
            default: begin
                used_cnt   = 0;
                free_depth = 0;
                r.ok       = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Sends one command beat; start stays high unless an idle gap is drawn.
    task automatic issue_cmd(t_gst_op op, logic [PAYLOAD_BITS-1:0] pay,
                             logic [SLOT_BITS-1:0] hs, logic [GEN_BITS-1:0] hg);
        t_table_result predicted;
        start         <= 1'b1;
        i_op          <= op;
        i_payload_in  <= pay;
        i_handle_slot <= hs;
        i_handle_gen  <= hg;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = table_model_step(op, pay, hs, hg);
        pending_results.insert(pending_results.size(), predicted);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        issue_cmd(OP_RESOLVE, '0, 8'd0, 16'd0);          // empty table
        issue_cmd(OP_REMOVE, '0, 8'd0, 16'd0);
        issue_cmd(OP_ADD, 32'h0000_0000, 8'd0, 16'd0);
        issue_cmd(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        issue_cmd(OP_RESOLVE, '0, 8'd0, 16'd0);
        issue_cmd(OP_RESOLVE, '1, 8'd1, 16'd0);
        issue_cmd(OP_RESOLVE, '0, 8'd1, 16'hFFFF);       // generation mismatch
        issue_cmd(OP_RESOLVE, '0, 8'd2, 16'd0);          // beyond used slots
        issue_cmd(OP_REMOVE, '0, 8'hFF, 16'hFFFF);
        issue_cmd(OP_REMOVE, '0, 8'd0, 16'd0);
        issue_cmd(OP_RESOLVE, '0, 8'd0, 16'd0);          // slot no longer occupied
        issue_cmd(OP_REMOVE, '0, 8'd0, 16'd0);
        issue_cmd(OP_RESOLVE, '0, 8'd0, 16'd1);
        issue_cmd(OP_ADD, 32'hA5A5_A5A5, 8'd0, 16'd0);   // reuse from free stack
        issue_cmd(OP_RESOLVE, '0, 8'd0, 16'd1);
        issue_cmd(OP_CLEAR, '1, 8'hFF, 16'hFFFF);
        issue_cmd(OP_RESOLVE, '0, 8'd0, 16'd1);
        issue_cmd(OP_ADD, 32'h5A5A_5A5A, 8'd0, 16'd0);   // fresh slot, generation 0
        end_burst();
    endtask

    task automatic test_table_full();
        idle_pct = 16;
        issue_cmd(OP_CLEAR, '0, 8'd0, 16'd0);
        repeat (SLOTS) issue_cmd(OP_ADD, $urandom, 8'd0, 16'd0);
        issue_cmd(OP_ADD, $urandom, 8'd0, 16'd0);        // full
        issue_cmd(OP_RESOLVE, '0, 8'hFF, 16'd0);
        issue_cmd(OP_REMOVE, '0, 8'hFF, 16'd0);
        issue_cmd(OP_ADD, $urandom, 8'd0, 16'd0);
        issue_cmd(OP_ADD, $urandom, 8'd0, 16'd0);
        end_burst();
    endtask

    // Recycles one slot through a run of generations, then pokes it with stale handles.
    task automatic test_retired_slot();
        idle_pct = 0;
        issue_cmd(OP_CLEAR, '0, 8'd0, 16'd0);
        issue_cmd(OP_ADD, $urandom, 8'd0, 16'd0);
        for (int g = 0; g < GEN_WALK; g++) begin
            issue_cmd(OP_REMOVE, '0, 8'd0, g[GEN_BITS-1:0]);
            issue_cmd(OP_ADD, $urandom, 8'd0, 16'd0);
        end
        issue_cmd(OP_REMOVE, '0, 8'd0, GEN_ALL_ONES);
        issue_cmd(OP_RESOLVE, '0, 8'd0, GEN_ALL_ONES);
        issue_cmd(OP_REMOVE, '0, 8'd0, GEN_ALL_ONES);
        issue_cmd(OP_ADD, $urandom, 8'd0, 16'd0);        // must take a fresh slot
        end_burst();
    endtask

    task automatic test_random_traffic();
        int unsigned          pick;
        logic [SLOT_BITS-1:0] hs;
        logic [GEN_BITS-1:0]  hg;
        t_gst_op              op;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1:       idle_pct = 74;
                3:       idle_pct = 16;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                pick = $urandom_range(99);
                hs   = SLOT_BITS'($urandom_range(255));
                hg   = GEN_BITS'($urandom_range(65535));
                if (pick < 1) begin
                    op = OP_CLEAR;
                end else if (pick < 40) begin
                    op = OP_ADD;
                end else begin
                    op = (pick < 70) ? OP_RESOLVE : OP_REMOVE;
                    // mostly handles taken from the table, some noise
                    if (pick % 10 != 0 && used_cnt > 0) begin
                        hs = SLOT_BITS'($urandom_range(used_cnt - 1));
                        hg = gen_mem[hs];
                        if ($urandom_range(9) == 0) hg = hg + GEN_BITS'($urandom_range(1, 3));
                    end
                end
                issue_cmd(op, $urandom, hs, hg);
            end
        end
        end_burst();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected beat: ok %b slot %h gen %h payload %h",
                         $time, o_ok, o_out_slot, o_out_gen, o_payload_out);
            end else begin
                oldest = pending_results.pop_front();
                if (o_ok !== oldest.ok) begin
                    fail_count++;
                    $display("%0t: ok exp %b got %b", $time, oldest.ok, o_ok);
                end
                if (o_out_slot !== oldest.slot) begin
                    fail_count++;
                    $display("%0t: slot exp %h got %h", $time, oldest.slot, o_out_slot);
                end
                if (o_out_gen !== oldest.gen) begin
                    fail_count++;
                    $display("%0t: gen exp %h got %h", $time, oldest.gen, o_out_gen);
                end
                if (o_payload_out !== oldest.payload) begin
                    fail_count++;
                    $display("%0t: payload exp %h got %h", $time, oldest.payload,
                             o_payload_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d beats outstanding", $time,
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_retired_slot();
        test_random_traffic();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
